FILE: rtl/mbsve_pkg.sv
// Shared types, register indexes and constants of the button scan value engine.
package mbsve_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANK       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_STEPS        = 3'd5;

    localparam logic [1:0]         ACTIVE_BANK_RST = 2'd0;
    localparam logic [15:0]        PRESS_TH_RST    = 16'd60000;
    localparam logic [15:0]        RELEASE_TH_RST  = 16'd200;
    localparam logic signed [15:0] VALUE_MIN_RST   = 16'sd0;
    localparam logic signed [15:0] VALUE_MAX_RST   = 16'sd127;
    localparam logic [7:0]         MODE_STEPS_RST  = 8'd0;

    // Button served at each mux input; the upper half belongs to converter A.
    localparam logic [3:0] BTN_MAP [16] = '{
        4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd9, 4'd12, 4'd13,
        4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15
    };

    typedef struct packed {
        logic [15:0] sample_a;
        logic [15:0] sample_b;
    } in_t;

    typedef struct packed {
        logic [2:0]         mux_select;
        logic               event_a;
        logic [3:0]         button_a;
        logic               pressed_a;
        logic signed [15:0] value_a;
        logic               event_b;
        logic [3:0]         button_b;
        logic               pressed_b;
        logic signed [15:0] value_b;
    } out_t;

    typedef struct packed {
        logic [15:0]        press_th;
        logic [15:0]        release_th;
        logic signed [15:0] value_min;
        logic signed [15:0] value_max;
        logic [7:0]         mode_steps;
    } cfg_t;

    // One classified sample pair as handed from the front to the back.
    typedef struct packed {
        logic [2:0] mux_select;
        logic [3:0] button_a;
        logic       read_a;
        logic       level_a;
        logic [3:0] button_b;
        logic       read_b;
        logic       level_b;
    } item_t;

    // One word of the button state memory.
    typedef struct packed {
        logic               level;
        logic signed [15:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_A,
        ST_B,
        ST_OUT
    } back_state_t;

endpackage

FILE: rtl/mbsve_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbsve_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/mbsve_front.sv
// Front end: accepts sample pairs, classifies them and tracks the scan position.
module mbsve_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mbsve_pkg::in_t      in_data,
    input  mbsve_pkg::cfg_t     cfg,
    input  logic                q_full,
    output logic                push,
    output mbsve_pkg::item_t    push_item
);

    logic [mbsve_pkg::POS_W-1:0] pos_reg;
    logic [mbsve_pkg::POS_W-1:0] pos_next;
    logic                        press_a;
    logic                        press_b;

    always_comb
    begin
        in_stall = q_full;
        push     = in_valid && !q_full;

        // The press test comes first, so it wins when both thresholds are met.
        press_a = in_data.sample_a > cfg.press_th;
        press_b = in_data.sample_b > cfg.press_th;

        push_item.mux_select = pos_reg + 1'b1;
        push_item.button_a   = mbsve_pkg::BTN_MAP[{1'b1, pos_reg}];
        push_item.read_a     = press_a || (in_data.sample_a < cfg.release_th);
        push_item.level_a    = !press_a;
        push_item.button_b   = mbsve_pkg::BTN_MAP[{1'b0, pos_reg}];
        push_item.read_b     = press_b || (in_data.sample_b < cfg.release_th);
        push_item.level_b    = !press_b;

        pos_next = push ? push_item.mux_select : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/mbsve_queue.sv
// Two-entry queue of classified items between the front and the back.
module mbsve_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mbsve_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output mbsve_pkg::item_t pop_item,
    output logic             empty
);

    mbsve_pkg::item_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_comb
    begin
        full        = count_reg == 2'd2;
        empty       = count_reg == 2'd0;
        pop_item    = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/mbsve_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module mbsve_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] dividend,
    input  logic [7:0]         divisor,
    output logic               done,
    output logic signed [16:0] quotient
);

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         cnt_reg;
    logic [15:0]        shift_reg;
    logic [7:0]         rem_reg;
    logic [7:0]         dvs_reg;
    logic               neg_reg;
    logic signed [16:0] quot_reg;

    logic [16:0]        abs_dividend;
    logic [8:0]         trial;
    logic [8:0]         trial_diff;
    logic               fits;
    logic [7:0]         rem_step;
    logic [15:0]        shift_step;
    logic signed [16:0] mag;
    logic signed [16:0] quot_final;

    always_comb
    begin
        abs_dividend = dividend[16] ? 17'(-dividend) : 17'(dividend);
        trial        = {rem_reg, shift_reg[15]};
        fits         = trial >= {1'b0, dvs_reg};
        trial_diff   = trial - {1'b0, dvs_reg};
        // For a nonzero divisor the remainder stays below it, so eight bits hold it.
        rem_step     = fits ? trial_diff[7:0] : trial[7:0];
        shift_step   = {shift_reg[14:0], fits};
        mag          = $signed({1'b0, shift_step});
        quot_final   = neg_reg ? -mag : mag;
        done         = done_reg;
        quotient     = quot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 4'd15)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= abs_dividend[15:0];
            rem_reg   <= '0;
            dvs_reg   <= divisor;
            neg_reg   <= dividend[16];
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_step;
            rem_reg   <= rem_step;
            if (cnt_reg == 4'd15)
            begin
                quot_reg <= quot_final;
            end
        end
    end

endmodule

FILE: rtl/mbsve_back.sv
// Back end: runs the step division and the read-modify-write of both buttons.
module mbsve_back #(
    parameter int BANKS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbsve_pkg::cfg_t    cfg,
    input  logic [1:0]         active_bank,
    input  logic               q_empty,
    output logic               pop,
    input  mbsve_pkg::item_t   pop_item,
    output logic               div_start,
    output logic signed [16:0] div_dividend,
    output logic [7:0]         div_divisor,
    input  logic               div_done,
    input  logic signed [16:0] div_quotient,
    output logic               out_valid,
    input  logic               out_stall,
    output mbsve_pkg::out_t    out_data
);

    localparam int DEPTH  = BANKS * 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;

    mbsve_pkg::back_state_t  state_reg;
    mbsve_pkg::back_state_t  state_next;
    mbsve_pkg::item_t        item_reg;
    mbsve_pkg::item_t        item_next;
    mbsve_pkg::out_t         work_reg;
    mbsve_pkg::out_t         work_next;
    mbsve_pkg::out_t         out_reg;
    mbsve_pkg::out_t         out_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DEPTH-1:0]        valid_reg;
    logic [DEPTH-1:0]        valid_next;

    logic [2:0]              bank_mod;
    logic [BANK_W-1:0]       bank_sel;
    logic [BANK_W+3:0]       cat_a;
    logic [BANK_W+3:0]       cat_b;
    logic [SLOT_W-1:0]       slot_a;
    logic [SLOT_W-1:0]       slot_b;
    logic [SLOT_W-1:0]       cur_slot;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [mbsve_pkg::ENTRY_W-1:0] ram_rdata;
    mbsve_pkg::entry_t       cur;
    mbsve_pkg::entry_t       upd;
    logic                    side_read;
    logic                    side_level;
    logic                    side_event;
    logic                    side_pressed;

    function automatic mbsve_pkg::entry_t serve_fn(
        input mbsve_pkg::entry_t  e,
        input logic               rd,
        input logic               lvl,
        input mbsve_pkg::cfg_t    c,
        input logic signed [16:0] step
    );
        mbsve_pkg::entry_t  n;
        logic signed [17:0] sum;
        logic signed [17:0] top;
        n   = e;
        sum = $signed({{2{e.value[15]}}, e.value}) + $signed({step[16], step});
        top = $signed({{2{c.value_max[15]}}, c.value_max});
        if (rd && (lvl != e.level))
        begin
            n.level = lvl;
            if (c.mode_steps == 8'd0)
            begin
                n.value = lvl ? c.value_min : c.value_max;
            end
            else if (!lvl)
            begin
                // A step past the top of the range wraps to the bottom.
                n.value = (sum > top) ? c.value_min : sum[15:0];
            end
        end
        return n;
    endfunction

    mbsve_ram #(
        .WIDTH (mbsve_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cur_slot),
        .wr_data (upd),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Bank and slot selection; the bank register is taken modulo BANKS.
    always_comb
    begin
        bank_mod = {1'b0, active_bank};
        for (int i = 0; i < 3; i++)
        begin
            if (int'(bank_mod) >= BANKS)
            begin
                bank_mod = bank_mod - 3'(BANKS);
            end
        end
        bank_sel = BANK_W'(bank_mod);
        cat_a    = {bank_sel, item_reg.button_a};
        cat_b    = {bank_sel, item_reg.button_b};
        slot_a   = cat_a[SLOT_W-1:0];
        slot_b   = cat_b[SLOT_W-1:0];
    end

    always_comb
    begin
        div_dividend = $signed({cfg.value_max[15], cfg.value_max})
                     - $signed({cfg.value_min[15], cfg.value_min});
        div_divisor  = cfg.mode_steps;

        // Read data in ST_A belongs to button A, in ST_B to button B.
        ram_raddr = (state_reg == mbsve_pkg::ST_A) ? slot_b : slot_a;
        cur_slot  = (state_reg == mbsve_pkg::ST_B) ? slot_b : slot_a;
        // An entry never written since reset reads as zero.
        cur       = valid_reg[cur_slot] ? mbsve_pkg::entry_t'(ram_rdata) : '0;

        side_read    = (state_reg == mbsve_pkg::ST_B) ? item_reg.read_b : item_reg.read_a;
        side_level   = (state_reg == mbsve_pkg::ST_B) ? item_reg.level_b : item_reg.level_a;
        side_event   = side_read && (side_level != cur.level);
        side_pressed = side_event && !side_level;
        upd          = serve_fn(cur, side_read, side_level, cfg, div_quotient);
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        valid_next     = valid_reg;
        pop            = 1'b0;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            mbsve_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop                  = 1'b1;
                    div_start            = 1'b1;
                    item_next            = pop_item;
                    work_next            = '0;
                    work_next.mux_select = pop_item.mux_select;
                    work_next.button_a   = pop_item.button_a;
                    work_next.button_b   = pop_item.button_b;
                    state_next           = mbsve_pkg::ST_DIV;
                end
            end
            mbsve_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mbsve_pkg::ST_A;
                end
            end
            mbsve_pkg::ST_A:
            begin
                ram_we               = 1'b1;
                valid_next[cur_slot] = 1'b1;
                work_next.event_a    = side_event;
                work_next.pressed_a  = side_pressed;
                work_next.value_a    = upd.value;
                state_next           = mbsve_pkg::ST_B;
            end
            mbsve_pkg::ST_B:
            begin
                ram_we               = 1'b1;
                valid_next[cur_slot] = 1'b1;
                work_next.event_b    = side_event;
                work_next.pressed_b  = side_pressed;
                work_next.value_b    = upd.value;
                state_next           = mbsve_pkg::ST_OUT;
            end
            mbsve_pkg::ST_OUT:
            begin
                if (!out_valid_next)
                begin
                    out_next       = work_reg;
                    out_valid_next = 1'b1;
                    state_next     = mbsve_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbsve_pkg::ST_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbsve_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        work_reg <= work_next;
        out_reg  <= out_next;
    end

endmodule

FILE: rtl/muxed_button_scan_value_engine.sv
// Top level of the multiplexed button scanner with value engine.
// Each sample pair goes through the bit-serial step divider and two read-modify-write
// passes over the state memory, one button per pass. The back end starts a new pair
// only once the last has gone to the output register; the queue holds up to two pairs.
// Reset: asynchronous, active low; scan position and registers return to their defaults,
// and per-entry valid bits make all button levels and values read as zero at once.
module muxed_button_scan_value_engine #(
    parameter int BANKS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  mbsve_pkg::in_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output mbsve_pkg::out_t                      out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbsve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbsve_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mbsve_pkg::cfg_t    cfg_reg;
    mbsve_pkg::cfg_t    cfg_next;
    logic [1:0]         bank_reg;
    logic [1:0]         bank_next;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    mbsve_pkg::item_t   q_item_in;
    mbsve_pkg::item_t   q_item_out;

    logic               div_start;
    logic signed [16:0] div_dividend;
    logic [7:0]         div_divisor;
    logic               div_done;
    logic signed [16:0] div_quotient;

    // Register writes are taken every cycle; writes beyond the list are dropped.
    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        bank_next = bank_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                mbsve_pkg::CFG_ACTIVE_BANK:       bank_next           = cfg_data[1:0];
                mbsve_pkg::CFG_PRESS_THRESHOLD:   cfg_next.press_th   = cfg_data;
                mbsve_pkg::CFG_RELEASE_THRESHOLD: cfg_next.release_th = cfg_data;
                mbsve_pkg::CFG_VALUE_MIN:         cfg_next.value_min  = $signed(cfg_data);
                mbsve_pkg::CFG_VALUE_MAX:         cfg_next.value_max  = $signed(cfg_data);
                mbsve_pkg::CFG_MODE_STEPS:        cfg_next.mode_steps = cfg_data[7:0];
                default:                          cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg           <= mbsve_pkg::ACTIVE_BANK_RST;
            cfg_reg.press_th   <= mbsve_pkg::PRESS_TH_RST;
            cfg_reg.release_th <= mbsve_pkg::RELEASE_TH_RST;
            cfg_reg.value_min  <= mbsve_pkg::VALUE_MIN_RST;
            cfg_reg.value_max  <= mbsve_pkg::VALUE_MAX_RST;
            cfg_reg.mode_steps <= mbsve_pkg::MODE_STEPS_RST;
        end
        else
        begin
            bank_reg <= bank_next;
            cfg_reg  <= cfg_next;
        end
    end

    mbsve_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_item_in)
    );

    mbsve_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item_out),
        .empty     (q_empty)
    );

    mbsve_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    mbsve_back #(
        .BANKS (BANKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .active_bank  (bank_reg),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .pop_item     (q_item_out),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule
